// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by semver_string_validator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/svv_pkg.sv -----
// Types and constants for the version string checker
`timescale 1ns / 1ps
`default_nettype none

package svv_pkg;

   localparam int CHAR_W    = 8;
   localparam int NUM_W     = 32;
   localparam int LEN_OUT_W = 16;

   localparam logic [CHAR_W-1:0] CHR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHR_UP_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHR_UP_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CHR_LO_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHR_LO_Z  = 8'h7A;

   typedef enum logic [2:0] {
      PH_MAJOR,
      PH_MINOR,
      PH_PATCH,
      PH_PRE,
      PH_BUILD,
      PH_FAIL
   } phase_type;

   typedef struct packed {
      logic                 done_res;
      logic                 valid_res;
      logic [NUM_W-1:0]     major_value;
      logic [NUM_W-1:0]     minor_value;
      logic [NUM_W-1:0]     patch_value;
      logic [LEN_OUT_W-1:0] prerelease_length;
      logic                 has_build;
      logic [LEN_OUT_W-1:0] build_length;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ----- hw/rtl/svv_channels.sv -----
// Request, response and register write channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface svv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface svv_rsp_if;
   logic        valid;
   logic        ready;
   logic        done_res;
   logic        valid_res;
   logic [31:0] major_value;
   logic [31:0] minor_value;
   logic [31:0] patch_value;
   logic [15:0] prerelease_length;
   logic        has_build;
   logic [15:0] build_length;

   modport source (output valid, output done_res, output valid_res, output major_value,
                   output minor_value, output patch_value, output prerelease_length,
                   output has_build, output build_length, input ready);
   modport sink (input valid, input done_res, input valid_res, input major_value,
                 input minor_value, input patch_value, input prerelease_length,
                 input has_build, input build_length, output ready);
endinterface

interface svv_csr_if;
   logic valid;
   logic ready;
   logic production_only;

   modport source (output valid, output production_only, input ready);
   modport sink (input valid, input production_only, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/semver_string_validator.sv -----
// Version string checker: one character per request, one response per request.
//
// req_ch carries one character of a version string per request; a zero
// byte ends the string. Every request gives one response on rsp_ch. For
// ordinary characters the response is all zeros; for the terminator it
// has done_res set, valid_res, the three numbers and the part lengths
// (all zero when the string is malformed).
// csr_ch writes production_only; it is always ready and should only be
// written with no request in flight.
// The response is registered and appears in the cycle after the request
// is taken. Throughput: one request per cycle unless rsp_ch stalls; the
// per-character state update is a single pass through the parser logic
// into the state registers. The response register holds while rsp_ch.ready
// is low; a new request is taken in the same cycle the held response
// leaves, so a stall on rsp_ch stalls req_ch with no bubble.
// Reset clears the parse state, the response valid flag and
// production_only.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module semver_string_validator #(
   parameter int MAX_NUMBER_DIGITS = 31,
   parameter int LENGTH_BITS       = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   svv_req_if.sink   req_ch,
   svv_rsp_if.source rsp_ch,
   svv_csr_if.sink   csr_ch
);
   import svv_pkg::*;

   logic            prod_only_ff, prod_only_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   rsp_payload_type step_result;
   logic            req_take;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   svv_parser #(
      .MAX_NUMBER_DIGITS (MAX_NUMBER_DIGITS),
      .LENGTH_BITS       (LENGTH_BITS)
   ) u_parser (
      .clock           (clock),
      .reset           (reset),
      .step            (req_take),
      .char_code       (req_ch.char_code),
      .production_only (prod_only_ff),
      .result          (step_result)
   );

   always_comb begin
      prod_only_in = (csr_ch.valid) ? csr_ch.production_only : prod_only_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_result;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_only_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prod_only_ff <= prod_only_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.done_res          = rsp_data_ff.done_res;
   assign rsp_ch.valid_res         = rsp_data_ff.valid_res;
   assign rsp_ch.major_value       = rsp_data_ff.major_value;
   assign rsp_ch.minor_value       = rsp_data_ff.minor_value;
   assign rsp_ch.patch_value       = rsp_data_ff.patch_value;
   assign rsp_ch.prerelease_length = rsp_data_ff.prerelease_length;
   assign rsp_ch.has_build         = rsp_data_ff.has_build;
   assign rsp_ch.build_length      = rsp_data_ff.build_length;

   `ASSERT_NEXT(a_take_gives_rsp, clock, reset, req_take, rsp_ch.valid)
   `ASSERT_IMPL(a_stall_blocks_req, clock, reset, rsp_valid_ff && !rsp_ch.ready, !req_ch.ready)
   `ASSERT_IMPL(a_valid_only_on_done, clock, reset, rsp_ch.valid && rsp_ch.valid_res,
                rsp_ch.done_res)
   `ASSERT_IMPL(a_build_implies_valid, clock, reset, rsp_ch.valid && rsp_ch.has_build,
                rsp_ch.valid_res && (rsp_ch.build_length != '0))

endmodule

`default_nettype wire

// ----- hw/rtl/svv_parser.sv -----
// Per-character parse state and next-state / result logic
`timescale 1ns / 1ps
`default_nettype none

module svv_parser #(
   parameter int MAX_NUMBER_DIGITS = 31,
   parameter int LENGTH_BITS       = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic [7:0]              char_code,
   input  wire logic                    production_only,
   output svv_pkg::rsp_payload_type     result
);
   import svv_pkg::*;

   localparam int DW = $clog2(MAX_NUMBER_DIGITS + 1);
   localparam int LW = (LENGTH_BITS < LEN_OUT_W) ? LENGTH_BITS : LEN_OUT_W;

   phase_type         phase_ff, phase_in;
   logic [NUM_W-1:0]  acc_ff, acc_in;
   logic [DW-1:0]     dcnt_ff, dcnt_in;
   logic              lz_ff, lz_in;
   logic [NUM_W-1:0]  major_ff, major_in;
   logic [NUM_W-1:0]  minor_ff, minor_in;
   logic [NUM_W-1:0]  patch_ff, patch_in;
   logic [1:0]        ilen_ff, ilen_in;
   logic              izero_ff, izero_in;
   logic              itail_ff, itail_in;
   logic [LW-1:0]     pre_ff, pre_in;
   logic [LW-1:0]     build_ff, build_in;

   logic              is_digit, is_ident;
   logic              digit_ok;
   logic [NUM_W+3:0]  acc_x10;
   logic [NUM_W-1:0]  acc_next;
   logic              ok_pre, ok_build;
   logic              str_ok;
   logic [LW-1:0]     pre_inc, build_inc;

   assign is_digit = (char_code >= CHR_ZERO) && (char_code <= CHR_NINE);
   assign is_ident = is_digit || (char_code == CHR_MINUS)
                  || ((char_code >= CHR_UP_A) && (char_code <= CHR_UP_Z))
                  || ((char_code >= CHR_LO_A) && (char_code <= CHR_LO_Z));

   assign digit_ok = (dcnt_ff < DW'(MAX_NUMBER_DIGITS)) && !((dcnt_ff == DW'(1)) && lz_ff);
   assign acc_x10  = ({4'b0000, acc_ff} << 3) + ({4'b0000, acc_ff} << 1)
                   + (NUM_W+4)'(char_code[3:0]);
   assign acc_next = (|acc_x10[NUM_W+3:NUM_W]) ? '1 : acc_x10[NUM_W-1:0];

   assign ok_build = (ilen_ff != 2'd0);
   assign ok_pre   = ok_build && !(izero_ff && (ilen_ff >= 2'd2) && itail_ff);

   assign pre_inc   = (pre_ff == '1) ? pre_ff : pre_ff + LW'(1);
   assign build_inc = (build_ff == '1) ? build_ff : build_ff + LW'(1);

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      dcnt_in  = dcnt_ff;
      lz_in    = lz_ff;
      major_in = major_ff;
      minor_in = minor_ff;
      patch_in = patch_ff;
      ilen_in  = ilen_ff;
      izero_in = izero_ff;
      itail_in = itail_ff;
      pre_in   = pre_ff;
      build_in = build_ff;
      result   = '0;
      str_ok   = 1'b0;

      if (step) begin
         if (char_code == CHR_NUL) begin
            unique case (phase_ff)
               PH_PATCH: str_ok = (dcnt_ff != '0);
               PH_PRE:   str_ok = ok_pre;
               PH_BUILD: str_ok = ok_build;
               default:  str_ok = 1'b0;
            endcase
            result.done_res = 1'b1;
            if (str_ok) begin
               result.valid_res         = 1'b1;
               result.major_value       = major_ff;
               result.minor_value       = minor_ff;
               result.patch_value       = (phase_ff == PH_PATCH) ? acc_ff : patch_ff;
               result.prerelease_length = LEN_OUT_W'(pre_ff);
               result.has_build         = (phase_ff == PH_BUILD);
               result.build_length      = LEN_OUT_W'(build_ff);
            end
            phase_in = PH_MAJOR;
            acc_in   = '0;
            dcnt_in  = '0;
            lz_in    = 1'b0;
            major_in = '0;
            minor_in = '0;
            patch_in = '0;
            ilen_in  = 2'd0;
            izero_in = 1'b0;
            itail_in = 1'b1;
            pre_in   = '0;
            build_in = '0;
         end else begin
            unique case (phase_ff) inside
               PH_MAJOR, PH_MINOR, PH_PATCH: begin
                  if (is_digit) begin
                     if (digit_ok) begin
                        acc_in  = acc_next;
                        dcnt_in = dcnt_ff + DW'(1);
                        if (dcnt_ff == '0) begin
                           lz_in = (char_code == CHR_ZERO);
                        end
                     end else begin
                        phase_in = PH_FAIL;
                     end
                  end else if (phase_ff != PH_PATCH) begin
                     if ((char_code == CHR_DOT) && (dcnt_ff != '0)) begin
                        if (phase_ff == PH_MAJOR) begin
                           major_in = acc_ff;
                           phase_in = PH_MINOR;
                        end else begin
                           minor_in = acc_ff;
                           phase_in = PH_PATCH;
                        end
                        acc_in  = '0;
                        dcnt_in = '0;
                        lz_in   = 1'b0;
                     end else begin
                        phase_in = PH_FAIL;
                     end
                  end else if (production_only || (dcnt_ff == '0)) begin
                     phase_in = PH_FAIL;
                  end else begin
                     patch_in = acc_ff;
                     ilen_in  = 2'd0;
                     izero_in = 1'b0;
                     itail_in = 1'b1;
                     if (char_code == CHR_MINUS) begin
                        phase_in = PH_PRE;
                        pre_in   = LW'(1);
                     end else if (char_code == CHR_PLUS) begin
                        phase_in = PH_BUILD;
                        build_in = LW'(1);
                     end else begin
                        phase_in = PH_FAIL;
                     end
                  end
               end
               PH_PRE, PH_BUILD: begin
                  if ((phase_ff == PH_PRE) && (char_code == CHR_PLUS)) begin
                     if (ok_pre) begin
                        ilen_in  = 2'd0;
                        izero_in = 1'b0;
                        itail_in = 1'b1;
                        phase_in = PH_BUILD;
                        build_in = LW'(1);
                     end else begin
                        phase_in = PH_FAIL;
                     end
                  end else begin
                     if (phase_ff == PH_PRE) begin
                        pre_in = pre_inc;
                     end else begin
                        build_in = build_inc;
                     end
                     if (char_code == CHR_DOT) begin
                        if ((phase_ff == PH_PRE) ? ok_pre : ok_build) begin
                           ilen_in  = 2'd0;
                           izero_in = 1'b0;
                           itail_in = 1'b1;
                        end else begin
                           phase_in = PH_FAIL;
                        end
                     end else if (is_ident) begin
                        if (ilen_ff == 2'd0) begin
                           izero_in = (char_code == CHR_ZERO);
                        end else if (!is_digit) begin
                           itail_in = 1'b0;
                        end
                        if (ilen_ff != 2'd3) begin
                           ilen_in = ilen_ff + 2'd1;
                        end
                     end else begin
                        phase_in = PH_FAIL;
                     end
                  end
               end
               default: phase_in = PH_FAIL;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAJOR;
         acc_ff   <= '0;
         dcnt_ff  <= '0;
         lz_ff    <= 1'b0;
         major_ff <= '0;
         minor_ff <= '0;
         patch_ff <= '0;
         ilen_ff  <= 2'd0;
         izero_ff <= 1'b0;
         itail_ff <= 1'b1;
         pre_ff   <= '0;
         build_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         dcnt_ff  <= dcnt_in;
         lz_ff    <= lz_in;
         major_ff <= major_in;
         minor_ff <= minor_in;
         patch_ff <= patch_in;
         ilen_ff  <= ilen_in;
         izero_ff <= izero_in;
         itail_ff <= itail_in;
         pre_ff   <= pre_in;
         build_ff <= build_in;
      end
   end

endmodule

`default_nettype wire
